// ===== rtl/core/idmr_pkg.sv =====
// ---------------------------------------------------------------------------
// idmr_pkg: shared types and constants
// Widths, configuration register indexes and the configuration bundle used
// by the int8 dense MAC / requantize core.
// ---------------------------------------------------------------------------
`default_nettype none

package idmr_pkg;

    // accumulator and field widths
    localparam int ACC_W    = 48;
    localparam int SCALER_W = 31;
    localparam int CFG_W    = 31;
    localparam int IDX_W    = 2;

    // configuration register indexes
    typedef enum logic [IDX_W-1:0] {
        REG_SCALER = 2'd0,
        REG_ZERO_POINT = 2'd1,
        REG_RELU = 2'd2,
        REG_QUANT_MODE = 2'd3
    } reg_index_t;

    // live configuration seen by the requantize side
    typedef struct packed {
        logic [SCALER_W-1:0] scaler;
        logic signed [7:0]   zero_point;
        logic                relu;
        logic                quant_mode;
    } cfg_t;

endpackage

`default_nettype wire

// ===== rtl/core/int8_dense_mac_requantize_core.sv =====
// ---------------------------------------------------------------------------
// int8_dense_mac_requantize_core: int8 dense-layer MAC with requantization
// Streams weight/activation pairs of output neurons and returns the raw sum
// and the requantized int8 value of each neuron.
// ---------------------------------------------------------------------------
// The front end accepts one weight/activation pair every cycle while full is
// low; the multiply-accumulate is combinational into a registered running
// sum. Each pair marked last places its 48-bit sum in a QUEUE_DEPTH-entry
// queue. The back end takes one sum at a time and takes no new sum until
// its result is popped: in quantized mode a bit-serial divider forms the
// quotient bit by bit; in raw mode the sum goes straight to the result.
// Runs long enough for the back end to keep up stream at one pair per
// cycle; short runs back up into full once the queue is filled.
// Configuration writes take effect at once and are meant for idle periods.
// ---------------------------------------------------------------------------
`default_nettype none

module int8_dense_mac_requantize_core
    import idmr_pkg::*;
#(
    parameter int QUEUE_DEPTH = 4
)
(
    input  wire logic               clk,
    input  wire logic               rst_n,
    // configuration write port
    input  wire logic               cfg_write,
    input  wire logic [IDX_W-1:0]   cfg_index,
    input  wire logic [CFG_W-1:0]   cfg_data,
    // request side
    input  wire logic               push,
    output logic                    full,
    input  wire logic signed [7:0]  weight,
    input  wire logic signed [7:0]  activation,
    input  wire logic signed [15:0] bias,
    input  wire logic signed [31:0] zero_point_sum,
    input  wire logic               first,
    input  wire logic               last,
    // result side
    output logic                    empty,
    input  wire logic               pop,
    output logic signed [ACC_W-1:0] raw_sum,
    output logic signed [7:0]       output_value
);

    cfg_t             cfg_reg;
    logic             accept;
    logic             sum_push;
    logic [ACC_W-1:0] sum_data;
    logic             q_pop;
    logic             q_empty;
    logic [ACC_W-1:0] q_data;

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.scaler     <= SCALER_W'(1);
            cfg_reg.zero_point <= '0;
            cfg_reg.relu       <= 1'b0;
            cfg_reg.quant_mode <= 1'b1;
        end
        else if (cfg_write)
        begin
            case (reg_index_t'(cfg_index))
                REG_SCALER:     cfg_reg.scaler     <= cfg_data[SCALER_W-1:0];
                REG_ZERO_POINT: cfg_reg.zero_point <= cfg_data[7:0];
                REG_RELU:       cfg_reg.relu       <= cfg_data[0];
                REG_QUANT_MODE: cfg_reg.quant_mode <= cfg_data[0];
                default:        cfg_reg            <= cfg_reg;
            endcase
        end
    end

    assign accept = push && !full;

    // front end
    idmr_mac u_mac (
        .clk            (clk),
        .rst_n          (rst_n),
        .accept         (accept),
        .weight         (weight),
        .activation     (activation),
        .bias           (bias),
        .zero_point_sum (zero_point_sum),
        .first          (first),
        .last           (last),
        .sum_push       (sum_push),
        .sum_data       (sum_data)
    );

    // queue between front and back
    idmr_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr_en   (sum_push),
        .wr_data (sum_data),
        .rd_en   (q_pop),
        .rd_data (q_data),
        .full    (full),
        .empty   (q_empty)
    );

    // back end
    idmr_requant u_requant (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg          (cfg_reg),
        .q_empty      (q_empty),
        .q_data       (q_data),
        .q_pop        (q_pop),
        .raw_sum      (raw_sum),
        .output_value (output_value),
        .empty        (empty),
        .pop          (pop)
    );

endmodule

`default_nettype wire

// ===== rtl/core/idmr_mac.sv =====
// ---------------------------------------------------------------------------
// idmr_mac: multiply-accumulate front end
// Takes one weight/activation pair per cycle while accept is high, keeps the
// running sum and hands a run's sum to the result queue on a last pair.
// ---------------------------------------------------------------------------
`default_nettype none

module idmr_mac
    import idmr_pkg::*;
(
    input  wire logic                    clk,
    input  wire logic                    rst_n,
    input  wire logic                    accept,
    input  wire logic signed [7:0]       weight,
    input  wire logic signed [7:0]       activation,
    input  wire logic signed [15:0]      bias,
    input  wire logic signed [31:0]      zero_point_sum,
    input  wire logic                    first,
    input  wire logic                    last,
    output logic                         sum_push,
    output logic [ACC_W-1:0]             sum_data
);

    logic [ACC_W-1:0]   acc_reg;
    logic [ACC_W-1:0]   acc_next;
    logic [ACC_W-1:0]   acc_base;
    logic signed [15:0] prod;

    // signed 8x8 product
    assign prod = weight * activation;

    // run start reloads with bias minus zero-point correction
    always_comb
    begin
        if (first)
        begin
            acc_base = ACC_W'($signed(bias)) - ACC_W'($signed(zero_point_sum));
        end
        else
        begin
            acc_base = acc_reg;
        end
        acc_next = acc_base + ACC_W'($signed(prod));
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            acc_reg <= '0;
        end
        else if (accept)
        begin
            acc_reg <= acc_next;
        end
    end

    // hand off on last pair
    assign sum_push = accept && last;
    assign sum_data = acc_next;

endmodule

`default_nettype wire

// ===== rtl/core/idmr_queue.sv =====
// ---------------------------------------------------------------------------
// idmr_queue: short result queue
// Small register FIFO of finished accumulator sums between the MAC front
// end and the requantize back end.
// ---------------------------------------------------------------------------
`default_nettype none

module idmr_queue
    import idmr_pkg::*;
#(
    parameter int DEPTH = 4
)
(
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             wr_en,
    input  wire logic [ACC_W-1:0] wr_data,
    input  wire logic             rd_en,
    output logic [ACC_W-1:0]      rd_data,
    output logic                  full,
    output logic                  empty
);

    localparam int PTR_W = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH + 1);

    logic [ACC_W-1:0] mem_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg;
    logic [PTR_W-1:0] rd_ptr_reg;
    logic [CNT_W-1:0] count_reg;
    logic             do_wr;
    logic             do_rd;

    assign full  = (count_reg == CNT_W'(DEPTH));
    assign empty = (count_reg == '0);
    assign do_wr = wr_en && !full;
    assign do_rd = rd_en && !empty;
    assign rd_data = mem_reg[rd_ptr_reg];

    // storage
    always_ff @(posedge clk)
    begin
        if (do_wr)
        begin
            mem_reg[wr_ptr_reg] <= wr_data;
        end
    end

    // pointers and fill count
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (do_wr)
            begin
                wr_ptr_reg <= (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
            end
            if (do_rd)
            begin
                rd_ptr_reg <= (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
            end
            if (do_wr && !do_rd)
            begin
                count_reg <= count_reg + 1'b1;
            end
            else if (do_rd && !do_wr)
            begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end

endmodule

`default_nettype wire

// ===== rtl/core/idmr_requant.sv =====
// ---------------------------------------------------------------------------
// idmr_requant: requantize back end
// Pulls one sum from the queue; in quantized mode it divides its magnitude
// by the scaler one quotient bit per cycle and applies ReLU and zero point;
// it holds the result until it is popped.
// ---------------------------------------------------------------------------
`default_nettype none

module idmr_requant
    import idmr_pkg::*;
(
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire cfg_t               cfg,
    input  wire logic               q_empty,
    input  wire logic [ACC_W-1:0]   q_data,
    output logic                    q_pop,
    output logic signed [ACC_W-1:0] raw_sum,
    output logic signed [7:0]       output_value,
    output logic                    empty,
    input  wire logic               pop
);

    localparam int BIT_W = $clog2(ACC_W);

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_DIV,
        ST_HOLD
    } state_t;

    state_t              state_reg;
    logic [ACC_W-1:0]    raw_reg;
    logic [7:0]          value_reg;
    logic [ACC_W-1:0]    quo_reg;
    logic [SCALER_W-1:0] rem_reg;
    logic [BIT_W-1:0]    bit_reg;
    logic                neg_reg;

    logic [SCALER_W-1:0] divisor;
    logic [ACC_W-1:0]    mag;
    logic [SCALER_W:0]   rem_sh;
    logic [SCALER_W:0]   rem_diff;
    logic                take;
    logic [ACC_W-1:0]    quo_next;
    logic [7:0]          qv;
    logic                positive;
    logic [7:0]          value_next;

    // zero scaler acts as one
    assign divisor = (cfg.scaler == '0) ? SCALER_W'(1) : cfg.scaler;
    assign mag     = q_data[ACC_W-1] ? (ACC_W'(0) - q_data) : q_data;

    // one restoring division step
    assign rem_sh   = {rem_reg, quo_reg[ACC_W-1]};
    assign rem_diff = rem_sh - {1'b0, divisor};
    assign take     = (rem_sh >= {1'b0, divisor});
    assign quo_next = {quo_reg[ACC_W-2:0], take};

    // final value from the completed quotient
    always_comb
    begin
        positive = !neg_reg && (quo_next != '0);
        qv       = neg_reg ? (8'd0 - quo_next[7:0]) : quo_next[7:0];
        if (cfg.relu && !positive)
        begin
            value_next = cfg.zero_point;
        end
        else
        begin
            value_next = qv + cfg.zero_point;
        end
    end

    assign q_pop = (state_reg == ST_IDLE) && !q_empty;

    // control and datapath registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            bit_reg   <= '0;
            raw_reg   <= '0;
            value_reg <= '0;
            quo_reg   <= '0;
            rem_reg   <= '0;
            neg_reg   <= 1'b0;
        end
        else
        begin
            case (state_reg)
                ST_IDLE:
                begin
                    if (!q_empty)
                    begin
                        raw_reg <= q_data;
                        neg_reg <= q_data[ACC_W-1];
                        quo_reg <= mag;
                        rem_reg <= '0;
                        bit_reg <= '0;
                        if (cfg.quant_mode)
                        begin
                            state_reg <= ST_DIV;
                        end
                        else
                        begin
                            value_reg <= '0;
                            state_reg <= ST_HOLD;
                        end
                    end
                end
                ST_DIV:
                begin
                    quo_reg <= quo_next;
                    rem_reg <= take ? rem_diff[SCALER_W-1:0] : rem_sh[SCALER_W-1:0];
                    bit_reg <= bit_reg + 1'b1;
                    if (bit_reg == BIT_W'(ACC_W - 1))
                    begin
                        value_reg <= value_next;
                        state_reg <= ST_HOLD;
                    end
                end
                ST_HOLD:
                begin
                    if (pop)
                    begin
                        state_reg <= ST_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    assign empty        = (state_reg != ST_HOLD);
    assign raw_sum      = raw_reg;
    assign output_value = value_reg;

endmodule

`default_nettype wire
